/* hw/rtl/icp_pkg.sv */
// Shared widths, types and codes of the incircle point classifier.
package icp_pkg;

   localparam int COORD_BITS     = 21;
   localparam int VERTICES       = 3;
   localparam int CFG_REGS       = 2 * VERTICES;
   localparam int CSR_INDEX_BITS = $clog2(CFG_REGS + 1);

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int LIFT_BITS  = PROD_BITS + 1;
   localparam int WIDE_BITS  = 2 * LIFT_BITS;
   localparam int DET_BITS   = WIDE_BITS + 2;

   localparam int LIMB_BITS  = 24;
   localparam int LIMBS      = (LIFT_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int EXT_BITS   = LIMBS * LIMB_BITS;
   localparam int PP_BITS    = 2 * (LIMB_BITS + 1);
   localparam int SUM_BITS   = 2 * EXT_BITS;

   localparam int STAGES        = 7;
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int CLASS_BITS    = 2;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_A_X = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_Y = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_X = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_Y = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_X = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] REG_C_Y = CSR_INDEX_BITS'(5);

   localparam logic [CLASS_BITS-1:0] CLASS_OUTSIDE  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_BOUNDARY = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_INSIDE   = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [LIFT_BITS-1:0]  lift_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;
   typedef logic [CLASS_BITS-1:0]        class_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

endpackage

/* hw/rtl/incircle_point_classifier.sv */
// Incircle point classifier: seven-stage pipeline, one query word per cycle while the result is not stalled.
// An accepted query passes through the lift, multiplier and sign stages in order before its class word is valid.
// Throughput: one word per cycle unless the result stalls; stage depth is set by the 25x25 limb multipliers.
// A stalled result holds only the stages behind it that are full; bubbles still fill.
// Reset clears all stage valid bits and sets every vertex coordinate to zero.
module incircle_point_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [20:0] query_x, [41:21] query_y, zero padded
   input  logic [icp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] position_class, zero padded
   output logic [icp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [icp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [icp_pkg::COORD_BITS-1:0]     csr_data
);
   import icp_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_en;
   point_type         vertex   [VERTICES];
   lift_type          lift_z   [VERTICES];
   lift_type          cofactor [VERTICES];
   wide_type          term     [VERTICES];
   class_type         position_class;
   coord_type         query_x;
   coord_type         query_y;

   assign query_x = coord_type'(req_tdata[COORD_BITS-1:0]);
   assign query_y = coord_type'(req_tdata[2*COORD_BITS-1:COORD_BITS]);

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = RSP_DATA_BITS'(position_class);

   icp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .vertex    (vertex)
   );

   icp_lift u_lift (
      .clock    (clock),
      .stage_en (stage_en[2:0]),
      .query_x  (query_x),
      .query_y  (query_y),
      .vertex   (vertex),
      .lift_z   (lift_z),
      .cofactor (cofactor)
   );

   for (genvar k = 0; k < VERTICES; k++) begin : g_term
      icp_wmul u_wmul (
         .clock    (clock),
         .stage_en (stage_en[4:3]),
         .mul_a    (lift_z[k]),
         .mul_b    (cofactor[k]),
         .product  (term[k])
      );
   end

   icp_sign u_sign (
      .clock          (clock),
      .stage_en       (stage_en[6:5]),
      .term           (term),
      .position_class (position_class)
   );

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted word missing from first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("word taken into a full stalled pipeline");

   a_bubble_takes: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_tready)
      else $error("empty first stage refuses a word");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == CLASS_OUTSIDE || rsp_tdata[1:0] == CLASS_BOUNDARY
                      || rsp_tdata[1:0] == CLASS_INSIDE))
      else $error("undefined class code on result word");

endmodule

/* hw/rtl/icp_cfg.sv */
// Vertex register file written through the configuration port.
module icp_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [icp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [icp_pkg::COORD_BITS-1:0]      csr_data,
   output icp_pkg::point_type                  vertex [icp_pkg::VERTICES]
);
   import icp_pkg::*;

   point_type vertex_ff [VERTICES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VERTICES; k++) begin
            vertex_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_A_X: vertex_ff[0].x <= coord_type'(csr_data);
            REG_A_Y: vertex_ff[0].y <= coord_type'(csr_data);
            REG_B_X: vertex_ff[1].x <= coord_type'(csr_data);
            REG_B_Y: vertex_ff[1].y <= coord_type'(csr_data);
            REG_C_X: vertex_ff[2].x <= coord_type'(csr_data);
            REG_C_Y: vertex_ff[2].y <= coord_type'(csr_data);
            default: ;
         endcase
      end
   end

   assign vertex = vertex_ff;

endmodule

/* hw/rtl/icp_lift.sv */
// Front stages: differences, lifted heights and the 2x2 cofactors.
module icp_lift (
   input  logic                clock,
   input  logic [2:0]          stage_en,
   input  icp_pkg::coord_type  query_x,
   input  icp_pkg::coord_type  query_y,
   input  icp_pkg::point_type  vertex [icp_pkg::VERTICES],
   output icp_pkg::lift_type   lift_z [icp_pkg::VERTICES],
   output icp_pkg::lift_type   cofactor [icp_pkg::VERTICES]
);
   import icp_pkg::*;

   logic signed [DIFF_BITS-1:0] dx_ff [VERTICES];
   logic signed [DIFF_BITS-1:0] dy_ff [VERTICES];
   logic signed [DIFF_BITS-1:0] sx_ff [VERTICES];
   logic signed [DIFF_BITS-1:0] sy_ff [VERTICES];
   logic signed [PROD_BITS-1:0] zx_ff [VERTICES];
   logic signed [PROD_BITS-1:0] zy_ff [VERTICES];
   logic signed [PROD_BITS-1:0] pa_ff [VERTICES];
   logic signed [PROD_BITS-1:0] pb_ff [VERTICES];
   lift_type                    z_ff  [VERTICES];
   lift_type                    c_ff  [VERTICES];

   for (genvar k = 0; k < VERTICES; k++) begin : g_vertex
      localparam int K1 = (k + 1) % VERTICES;
      localparam int K2 = (k + 2) % VERTICES;

      always_ff @(posedge clock) begin
         if (stage_en[0]) begin
            dx_ff[k] <= DIFF_BITS'(vertex[k].x) - DIFF_BITS'(query_x);
            dy_ff[k] <= DIFF_BITS'(vertex[k].y) - DIFF_BITS'(query_y);
            sx_ff[k] <= DIFF_BITS'(vertex[k].x) + DIFF_BITS'(query_x);
            sy_ff[k] <= DIFF_BITS'(vertex[k].y) + DIFF_BITS'(query_y);
         end
         if (stage_en[1]) begin
            zx_ff[k] <= dx_ff[k] * sx_ff[k];
            zy_ff[k] <= dy_ff[k] * sy_ff[k];
            pa_ff[k] <= dx_ff[K1] * dy_ff[K2];
            pb_ff[k] <= dx_ff[K2] * dy_ff[K1];
         end
         if (stage_en[2]) begin
            z_ff[k] <= LIFT_BITS'(zx_ff[k]) + LIFT_BITS'(zy_ff[k]);
            c_ff[k] <= LIFT_BITS'(pa_ff[k]) - LIFT_BITS'(pb_ff[k]);
         end
      end
   end

   assign lift_z   = z_ff;
   assign cofactor = c_ff;

endmodule

/* hw/rtl/icp_wmul.sv */
// Two-stage signed wide multiplier built from limb partial products.
module icp_wmul (
   input  logic               clock,
   input  logic [1:0]         stage_en,
   input  icp_pkg::lift_type  mul_a,
   input  icp_pkg::lift_type  mul_b,
   output icp_pkg::wide_type  product
);
   import icp_pkg::*;

   logic signed [EXT_BITS-1:0]  a_ext;
   logic signed [EXT_BITS-1:0]  b_ext;
   logic signed [LIMB_BITS:0]   a_limb [LIMBS];
   logic signed [LIMB_BITS:0]   b_limb [LIMBS];
   logic signed [PP_BITS-1:0]   pp_ff [LIMBS][LIMBS];
   logic signed [SUM_BITS-1:0]  acc;
   wide_type                    product_ff;

   always_comb begin
      a_ext = EXT_BITS'(mul_a);
      b_ext = EXT_BITS'(mul_b);
      for (int i = 0; i < LIMBS; i++) begin
         a_limb[i] = $signed({(i == LIMBS - 1) ? a_ext[EXT_BITS-1] : 1'b0,
                              a_ext[i*LIMB_BITS +: LIMB_BITS]});
         b_limb[i] = $signed({(i == LIMBS - 1) ? b_ext[EXT_BITS-1] : 1'b0,
                              b_ext[i*LIMB_BITS +: LIMB_BITS]});
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            acc = acc + (SUM_BITS'(pp_ff[i][j]) <<< (LIMB_BITS * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
               pp_ff[i][j] <= a_limb[i] * b_limb[j];
            end
         end
      end
      if (stage_en[1]) begin
         product_ff <= WIDE_BITS'(acc);
      end
   end

   assign product = product_ff;

endmodule

/* hw/rtl/icp_sign.sv */
// Final stages: sum the three cofactor terms and classify by sign.
module icp_sign (
   input  logic                clock,
   input  logic [1:0]          stage_en,
   input  icp_pkg::wide_type   term [icp_pkg::VERTICES],
   output icp_pkg::class_type  position_class
);
   import icp_pkg::*;

   logic signed [DET_BITS-1:0] det_in;
   logic signed [DET_BITS-1:0] det_ff;
   class_type                  class_in;
   class_type                  class_ff;

   always_comb begin
      det_in = '0;
      for (int k = 0; k < VERTICES; k++) begin
         det_in = det_in + DET_BITS'(term[k]);
      end
   end

   always_comb begin
      priority if (det_ff[DET_BITS-1]) begin
         class_in = CLASS_OUTSIDE;
      end else if (det_ff == '0) begin
         class_in = CLASS_BOUNDARY;
      end else begin
         class_in = CLASS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         det_ff <= det_in;
      end
      if (stage_en[1]) begin
         class_ff <= class_in;
      end
   end

   assign position_class = class_ff;

endmodule
